>>> hw/rtl/nrce_pkg.sv
// Shared types, character codes and the digit accumulate function for the
// NMEA RMC coordinate extractor. No dependencies.
`timescale 1ns / 1ps

package nrce_pkg;

    localparam int ACC_W      = 30;
    localparam int COUNT_W    = 4;
    localparam int BYTE_W     = 8;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W = 4;
    localparam int OUT_TDATA_W = 128;

    localparam logic [BYTE_W-1:0] CHAR_COMMA = 8'h2C;
    localparam logic [BYTE_W-1:0] CHAR_DOT   = 8'h2E;
    localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;

    localparam logic [COUNT_W-1:0] COUNT_MAX     = 4'd15;
    localparam logic [COUNT_W-1:0] LAT_INDEX_RST = 4'd3;
    localparam logic [COUNT_W-1:0] LON_INDEX_RST = 4'd5;
    localparam logic [ACC_W-1:0]   ACC_MAX       = 30'd999999999;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_LAT_FIELD_INDEX = 1'b0,
        REG_LON_FIELD_INDEX = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic              fire;
        logic [BYTE_W-1:0] byte_value;
        logic              end_of_text;
    } step_t;

    typedef struct packed {
        logic             valid;
        logic             parse_ok;
        logic [ACC_W-1:0] lat_whole;
        logic [ACC_W-1:0] lat_fraction;
        logic [ACC_W-1:0] lon_whole;
        logic [ACC_W-1:0] lon_fraction;
    } result_t;

    // Appends one decimal digit and saturates at the largest nine-digit value.
    function automatic logic [ACC_W-1:0] push_digit(input logic [ACC_W-1:0] acc,
                                                    input logic [3:0] digit);
        logic [ACC_W+3:0] sum;
        sum = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {{ACC_W{1'b0}}, digit};
        if (sum > {4'b0, ACC_MAX})
        begin
            return ACC_MAX;
        end
        return sum[ACC_W-1:0];
    endfunction

endpackage

>>> hw/rtl/nrce_in_stage.sv
// Input register for the character stream of the coordinate extractor.
// Depends on nrce_pkg.
`timescale 1ns / 1ps

module nrce_in_stage
    import nrce_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,    // byte_value
    input  logic              s_tlast,    // end_of_text
    input  logic              out_busy,
    output step_t             step
);

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] byte_reg;
    logic              eot_reg;
    logic              advance;

    // A character without the end mark never produces a result, so only an
    // end character has to wait for the output register.
    assign advance  = valid_reg && (!eot_reg || !out_busy);
    assign s_tready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_tready)
        begin
            valid_next = s_tvalid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            byte_reg <= s_tdata;
            eot_reg  <= s_tlast;
        end
    end

    assign step.fire        = advance;
    assign step.byte_value  = byte_reg;
    assign step.end_of_text = eot_reg;

endmodule

>>> hw/rtl/nrce_parser.sv
// Comma counting, field tracking and digit accumulation for one sentence.
// Holds the field index registers. Depends on nrce_pkg.
`timescale 1ns / 1ps

module nrce_parser
    import nrce_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  step_t                  step,
    output result_t                result
);

    logic [COUNT_W-1:0] lat_index_reg;
    logic [COUNT_W-1:0] lon_index_reg;
    logic [COUNT_W-1:0] comma_count_reg;
    logic [COUNT_W-1:0] comma_count_next;
    logic               field_stopped_reg;
    logic               field_stopped_next;
    logic               past_dot_reg;
    logic               past_dot_next;
    logic [ACC_W-1:0]   lat_whole_reg;
    logic [ACC_W-1:0]   lat_whole_next;
    logic [ACC_W-1:0]   lat_fraction_reg;
    logic [ACC_W-1:0]   lat_fraction_next;
    logic [ACC_W-1:0]   lon_whole_reg;
    logic [ACC_W-1:0]   lon_whole_next;
    logic [ACC_W-1:0]   lon_fraction_reg;
    logic [ACC_W-1:0]   lon_fraction_next;

    logic               is_comma;
    logic               is_dot;
    logic               is_crlf;
    logic               is_digit;
    logic [3:0]         digit;
    logic               lat_hit;
    logic               lon_hit;
    logic               ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lat_index_reg <= LAT_INDEX_RST;
            lon_index_reg <= LON_INDEX_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_LAT_FIELD_INDEX: lat_index_reg <= cfg_data;
                REG_LON_FIELD_INDEX: lon_index_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign is_comma = (step.byte_value == CHAR_COMMA);
    assign is_dot   = (step.byte_value == CHAR_DOT);
    assign is_crlf  = (step.byte_value == CHAR_CR) || (step.byte_value == CHAR_LF);
    assign is_digit = (step.byte_value >= CHAR_ZERO) && (step.byte_value <= CHAR_NINE);
    assign digit    = step.byte_value[3:0];
    assign lat_hit  = (lat_index_reg != '0) && (comma_count_reg == lat_index_reg);
    assign lon_hit  = (lon_index_reg != '0) && (comma_count_reg == lon_index_reg);

    always_comb
    begin
        comma_count_next   = comma_count_reg;
        field_stopped_next = field_stopped_reg;
        past_dot_next      = past_dot_reg;
        lat_whole_next     = lat_whole_reg;
        lat_fraction_next  = lat_fraction_reg;
        lon_whole_next     = lon_whole_reg;
        lon_fraction_next  = lon_fraction_reg;
        if (is_comma)
        begin
            if (comma_count_reg != COUNT_MAX)
            begin
                comma_count_next   = comma_count_reg + 4'd1;
                field_stopped_next = 1'b0;
                past_dot_next      = 1'b0;
            end
            else
            begin
                field_stopped_next = 1'b1;
            end
        end
        else if (!field_stopped_reg)
        begin
            priority if (is_crlf)
            begin
                field_stopped_next = 1'b1;
            end
            else if (is_dot)
            begin
                past_dot_next = 1'b1;
            end
            else if (is_digit)
            begin
                if (lat_hit && past_dot_reg)
                begin
                    lat_fraction_next = push_digit(lat_fraction_reg, digit);
                end
                if (lat_hit && !past_dot_reg)
                begin
                    lat_whole_next = push_digit(lat_whole_reg, digit);
                end
                if (lon_hit && past_dot_reg)
                begin
                    lon_fraction_next = push_digit(lon_fraction_reg, digit);
                end
                if (lon_hit && !past_dot_reg)
                begin
                    lon_whole_next = push_digit(lon_whole_reg, digit);
                end
            end
        end
    end

    assign ok = (lat_index_reg != '0) && (lon_index_reg != '0) &&
                (comma_count_next >= lat_index_reg) &&
                (comma_count_next >= lon_index_reg);

    assign result.valid        = step.fire && step.end_of_text;
    assign result.parse_ok     = ok;
    assign result.lat_whole    = ok ? lat_whole_next : '0;
    assign result.lat_fraction = ok ? lat_fraction_next : '0;
    assign result.lon_whole    = ok ? lon_whole_next : '0;
    assign result.lon_fraction = ok ? lon_fraction_next : '0;

    // The end character is folded in first, then the sentence state clears.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            comma_count_reg   <= '0;
            field_stopped_reg <= 1'b0;
            past_dot_reg      <= 1'b0;
            lat_whole_reg     <= '0;
            lat_fraction_reg  <= '0;
            lon_whole_reg     <= '0;
            lon_fraction_reg  <= '0;
        end
        else if (step.fire && step.end_of_text)
        begin
            comma_count_reg   <= '0;
            field_stopped_reg <= 1'b0;
            past_dot_reg      <= 1'b0;
            lat_whole_reg     <= '0;
            lat_fraction_reg  <= '0;
            lon_whole_reg     <= '0;
            lon_fraction_reg  <= '0;
        end
        else if (step.fire)
        begin
            comma_count_reg   <= comma_count_next;
            field_stopped_reg <= field_stopped_next;
            past_dot_reg      <= past_dot_next;
            lat_whole_reg     <= lat_whole_next;
            lat_fraction_reg  <= lat_fraction_next;
            lon_whole_reg     <= lon_whole_next;
            lon_fraction_reg  <= lon_fraction_next;
        end
    end

endmodule

>>> hw/rtl/nrce_out_stage.sv
// Result register and packing of the result transaction onto the master side.
// Depends on nrce_pkg.
`timescale 1ns / 1ps

module nrce_out_stage
    import nrce_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  result_t                result,
    output logic                   out_busy,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    logic             valid_reg;
    logic             valid_next;
    logic             ok_reg;
    logic [ACC_W-1:0] lat_whole_reg;
    logic [ACC_W-1:0] lat_fraction_reg;
    logic [ACC_W-1:0] lon_whole_reg;
    logic [ACC_W-1:0] lon_fraction_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (result.valid)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result.valid)
        begin
            ok_reg           <= result.parse_ok;
            lat_whole_reg    <= result.lat_whole;
            lat_fraction_reg <= result.lat_fraction;
            lon_whole_reg    <= result.lon_whole;
            lon_fraction_reg <= result.lon_fraction;
        end
    end

    assign out_busy = valid_reg && !m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = {7'b0, lon_fraction_reg, lon_whole_reg, lat_fraction_reg,
                       lat_whole_reg, ok_reg};

endmodule

>>> hw/rtl/nmea_rmc_coordinate_extract_core.sv
// Top level of the NMEA RMC coordinate extractor: input register, parser and
// result register. Depends on nrce_pkg, nrce_in_stage, nrce_parser, nrce_out_stage.
//
//   Channel   Signals                          Carries
//   s_*       s_tvalid s_tready s_tdata s_tlast  one sentence character per transaction
//   m_*       m_tvalid m_tready m_tdata          one coordinate result per sentence
//   cfg_*     cfg_we cfg_index cfg_data          latitude and longitude field indices
//
// One character is accepted every cycle unless an end character waits on a pending result;
// an accepted end character is held in the input register, then its result in the result register.
// Reset clears the sentence state and loads field indices 3 and 5.
// While a result waits on m_tready, plain characters keep flowing; the next end
// character waits in the input register until the result is taken.
`timescale 1ns / 1ps

module nmea_rmc_coordinate_extract_core
    import nrce_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [BYTE_W-1:0]      s_tdata,    // byte_value
    input  logic                   s_tlast,    // end_of_text
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // parse_ok, lat_whole, lat_fraction, lon_whole, lon_fraction, zero fill
    output logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    step_t   step;
    result_t result;
    logic    out_busy;

    nrce_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .out_busy (out_busy),
        .step     (step)
    );

    nrce_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (step),
        .result    (result)
    );

    nrce_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .result   (result),
        .out_busy (out_busy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

`ifndef SYNTH
    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (step.fire && step.end_of_text) |-> !(m_tvalid && !m_tready))
        else $error("End character advanced while a result was still waiting.");

    a_result_from_end_char: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(step.fire && step.end_of_text))
        else $error("Result appeared without an end character.");

    a_failed_parse_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[OUT_TDATA_W-1:1] == '0))
        else $error("Failed parse carries nonzero coordinates.");
`endif

endmodule
